// ----- hdl/ps2mt_pkg.sv -----
// shared constants and types for the ps/2 mouse packet tracker
`timescale 1ns / 1ps

package ps2mt_pkg;

    localparam int FIFO_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF = 12;

    localparam int SIZE_W       = 13;
    localparam int FRAC_W       = 32;
    localparam int BTN_W        = 3;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 768;

    // register indexes of the configuration port
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // input actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // result status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_WRITTEN = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // byte position within a packet
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // bit positions in the first packet byte
    localparam int FLAG_ALWAYS_ONE = 3;
    localparam int FLAG_X_SIGN     = 4;
    localparam int FLAG_Y_SIGN     = 5;
    localparam int FLAG_X_OVF      = 6;
    localparam int FLAG_Y_OVF      = 7;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [BTN_W-1:0] last_btn;
    } fifo_stat_t;

endpackage

// ----- hdl/ps2mt_fifo.sv -----
// event queue: packet memory with head, tail and fill count
`timescale 1ns / 1ps

module ps2mt_fifo
    import ps2mt_pkg::*;
#(
    parameter int DEPTH  = FIFO_DEPTH_DEF,
    parameter int DATA_W = BTN_W + 2 * COORD_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data,
    output fifo_stat_t        stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BTN_W-1:0]  last_btn_reg, last_btn_next;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        last_btn_next = last_btn_reg;
        if (ctrl.push)
        begin
            tail_next     = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next    = count_reg + 1'b1;
            last_btn_next = wr_data[BTN_W-1:0];
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            last_btn_reg <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            last_btn_reg <= last_btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data       = rd_data_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.last_btn = last_btn_reg;

endmodule

// ----- hdl/ps2mt_div.sv -----
// bit-serial restoring divider for the screen fraction, one quotient bit a cycle
`timescale 1ns / 1ps

module ps2mt_div
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend,
    input  logic [COORD_BITS:0]   divisor,
    output logic                  done,
    output logic [FRAC_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(FRAC_W + 1);
    localparam int RW    = COORD_BITS + 1;

    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     dvs_reg;
    logic [FRAC_W-1:0] quo_reg;

    logic [RW:0]       rem_dbl;
    logic [RW:0]       rem_sub;
    logic              fits;
    logic [RW-1:0]     rem_step;

    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        rem_sub  = rem_dbl - {1'b0, dvs_reg};
        fits     = (rem_dbl >= {1'b0, dvs_reg});
        rem_step = fits ? rem_sub[RW-1:0] : rem_dbl[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(FRAC_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // position at or past the screen edge saturates the fraction
            sat_reg <= ({1'b0, dividend} >= divisor);
            rem_reg <= {1'b0, dividend};
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : quo_reg;

endmodule

// ----- hdl/ps2_mouse_packet_tracker_core.sv -----
// top level: packet assembly, pointer tracking, event queue and host report
//
// Input channel (in_valid/in_ready) takes one item at a time: a mouse byte
// (action 0) or a host poll (action 1, skipped when host_busy is set).
// Every item yields exactly one result on the output channel
// (out_valid/out_ready): a status code, the shown buttons, the shown
// position as 32-bit fractions of the screen and the current pointer.
// Screen width and height are written on the cfg port (index 0 and 1); the
// user must write them only while the block is idle, as the block does not
// enforce it; cfg_ready is always high. A new item is taken only once the
// previous result has gone into the output register. In between, the event
// queue memory is read, then the shared bit-serial divider works out the x
// fraction and after it the y fraction.
// If the receiver stalls, the result waits in the output register and the
// block stops after finishing the next item until the register frees up.
// Reset returns the pointer to the middle of a 1024 by 768 screen, empties
// the event queue and clears the packet assembly state; queue contents are
// left as they are and only written entries are ever read.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_core
    import ps2mt_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [7:0]            data_byte,
    input  logic                  host_busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  button_left,
    output logic                  button_right,
    output logic                  button_middle,
    output logic [FRAC_W-1:0]     abs_x,
    output logic [FRAC_W-1:0]     abs_y,
    output logic [COORD_BITS-1:0] pointer_x,
    output logic [COORD_BITS-1:0] pointer_y
);

    localparam int CB     = COORD_BITS;
    localparam int EW     = CB + 1;
    localparam int PW     = CB + 2;
    localparam int CW     = (SIZE_W > EW) ? SIZE_W : EW;
    localparam int DATA_W = BTN_W + 2 * CB;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_DIVX  = 5'b00100,
        S_DIVY  = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CW-1:0] s_ext;
        logic [CW-1:0] lim;
        s_ext = CW'(s);
        lim   = CW'(1) << CB;
        if (s == '0)
            return EW'(1);
        else if (s_ext > lim)
            return EW'(lim);
        else
            return EW'(s_ext);
    endfunction

    function automatic logic signed [PW-1:0] movement(input logic [7:0] b, input logic sgn);
        return signed'({{(PW-8){sgn & b[7]}}, b});
    endfunction

    function automatic logic [CB-1:0] clamp_pos(input logic signed [PW-1:0] p,
                                                input logic [EW-1:0] eff);
        if (p < 0)
            return '0;
        else if (unsigned'(p) >= PW'(eff))
            return CB'(eff - 1'b1);
        else
            return CB'(p);
    endfunction

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [1:0]          phase_reg, phase_next;
    logic                drop_reg, drop_next;
    logic                enabled_reg, enabled_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          second_reg, second_next;
    logic [CB-1:0]       cur_x_reg, cur_x_next;
    logic [CB-1:0]       cur_y_reg, cur_y_next;
    logic [BTN_W-1:0]    shown_btn_reg, shown_btn_next;
    logic [CB-1:0]       shown_x_reg, shown_x_next;
    logic [CB-1:0]       shown_y_reg, shown_y_next;
    logic                pop_pend_reg, pop_pend_next;
    logic [1:0]          status_reg, status_next;
    logic [FRAC_W-1:0]   x_frac_reg, x_frac_next;

    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [BTN_W-1:0]    out_btn_reg;
    logic [FRAC_W-1:0]   out_abs_x_reg, out_abs_y_reg;
    logic [CB-1:0]       out_px_reg, out_py_reg;

    logic                in_fire, cfg_fire, out_free, load;
    logic [EW-1:0]       eff_w, eff_h;
    logic [BTN_W-1:0]    btn, last_btn;
    fifo_ctrl_t          fifo_ctrl;
    fifo_stat_t          fifo_stat;
    logic [DATA_W-1:0]   fifo_wdata, fifo_rdata;
    logic                div_start, div_done;
    logic [CB-1:0]       div_dividend;
    logic [EW-1:0]       div_divisor;
    logic [FRAC_W-1:0]   div_q;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign eff_w     = eff_size(width_reg);
    assign eff_h     = eff_size(height_reg);
    assign btn       = first_reg[BTN_W-1:0];
    assign last_btn  = fifo_stat.empty ? shown_btn_reg : fifo_stat.last_btn;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        drop_next      = drop_reg;
        enabled_next   = enabled_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        shown_btn_next = shown_btn_reg;
        shown_x_next   = shown_x_reg;
        shown_y_next   = shown_y_reg;
        pop_pend_next  = pop_pend_reg;
        status_next    = status_reg;
        x_frac_next    = x_frac_reg;
        fifo_ctrl      = '0;
        fifo_wdata     = '0;
        div_start      = 1'b0;
        div_dividend   = shown_x_reg;
        div_divisor    = eff_w;
        load           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next   = ST_NONE;
                    pop_pend_next = 1'b0;
                    state_next    = S_FETCH;
                    if (action == ACT_BYTE)
                    begin
                        case (phase_reg)
                            PH_SECOND:
                            begin
                                second_next = data_byte;
                                phase_next  = PH_THIRD;
                            end
                            PH_THIRD:
                            begin
                                phase_next = PH_FIRST;
                                if (drop_reg)
                                begin
                                    drop_next = 1'b0;
                                end
                                else
                                begin
                                    enabled_next = 1'b1;
                                    cur_x_next = clamp_pos(signed'(PW'(cur_x_reg))
                                        + movement(second_reg, first_reg[FLAG_X_SIGN]), eff_w);
                                    cur_y_next = clamp_pos(signed'(PW'(cur_y_reg))
                                        - movement(data_byte, first_reg[FLAG_Y_SIGN]), eff_h);
                                    // same buttons as the newest known state: no need to queue
                                    if (btn == last_btn)
                                    begin
                                        shown_btn_next = btn;
                                        shown_x_next   = cur_x_next;
                                        shown_y_next   = cur_y_next;
                                    end
                                    else if (fifo_stat.full)
                                    begin
                                        status_next = ST_DROPPED;
                                    end
                                    else
                                    begin
                                        fifo_ctrl.push = 1'b1;
                                        fifo_wdata     = {cur_y_next, cur_x_next, btn};
                                    end
                                end
                            end
                            default:
                            begin
                                first_next = data_byte;
                                phase_next = PH_SECOND;
                                if (data_byte[FLAG_X_OVF] || data_byte[FLAG_Y_OVF]
                                    || !data_byte[FLAG_ALWAYS_ONE])
                                begin
                                    drop_next = 1'b1;
                                end
                            end
                        endcase
                    end
                    else if (enabled_reg && !host_busy)
                    begin
                        status_next = ST_WRITTEN;
                        if (!fifo_stat.empty)
                        begin
                            fifo_ctrl.pop = 1'b1;
                            pop_pend_next = 1'b1;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                // queue read data is valid here, in the cycle after the pop
                if (pop_pend_reg)
                begin
                    shown_btn_next = fifo_rdata[BTN_W-1:0];
                    shown_x_next   = fifo_rdata[BTN_W +: CB];
                    shown_y_next   = fifo_rdata[BTN_W + CB +: CB];
                end
                div_start    = 1'b1;
                div_dividend = shown_x_next;
                div_divisor  = eff_w;
                state_next   = S_DIVX;
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    x_frac_next  = div_q;
                    div_start    = 1'b1;
                    div_dividend = shown_y_reg;
                    div_divisor  = eff_h;
                    state_next   = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= SIZE_W'(RESET_WIDTH);
            height_reg    <= SIZE_W'(RESET_HEIGHT);
            phase_reg     <= PH_FIRST;
            drop_reg      <= 1'b0;
            enabled_reg   <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            cur_x_reg     <= CB'(RESET_WIDTH / 2);
            cur_y_reg     <= CB'(RESET_HEIGHT / 2);
            shown_btn_reg <= '0;
            shown_x_reg   <= CB'(RESET_WIDTH / 2);
            shown_y_reg   <= CB'(RESET_HEIGHT / 2);
            pop_pend_reg  <= 1'b0;
            status_reg    <= ST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            drop_reg      <= drop_next;
            enabled_reg   <= enabled_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            shown_btn_reg <= shown_btn_next;
            shown_x_reg   <= shown_x_next;
            shown_y_reg   <= shown_y_next;
            pop_pend_reg  <= pop_pend_next;
            status_reg    <= status_next;
            if (cfg_fire)
            begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_frac_reg <= x_frac_next;
        if (load)
        begin
            out_status_reg <= status_reg;
            out_btn_reg    <= shown_btn_reg;
            out_abs_x_reg  <= x_frac_reg;
            out_abs_y_reg  <= div_q;
            out_px_reg     <= cur_x_reg;
            out_py_reg     <= cur_y_reg;
        end
    end

    ps2mt_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fifo_ctrl),
        .wr_data (fifo_wdata),
        .rd_data (fifo_rdata),
        .stat    (fifo_stat)
    );

    ps2mt_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign button_left   = out_btn_reg[0];
    assign button_right  = out_btn_reg[1];
    assign button_middle = out_btn_reg[2];
    assign abs_x         = out_abs_x_reg;
    assign abs_y         = out_abs_y_reg;
    assign pointer_x     = out_px_reg;
    assign pointer_y     = out_py_reg;

endmodule

// ----- hdl/ps2mt_checker.sv -----
// port-level checks for the packet tracker, bound to the top level
`timescale 1ns / 1ps

module ps2mt_checker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            status,
    input logic [FRAC_W-1:0]     abs_x,
    input logic [FRAC_W-1:0]     abs_y,
    input logic [COORD_BITS-1:0] pointer_x,
    input logic [COORD_BITS-1:0] pointer_y
);

    // one item in flight: after an accept the input side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is still in work");

    // a result is never produced in the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (!out_valid || out_ready)) |=> !out_valid)
        else $error("result appeared too early after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_NONE || status == ST_WRITTEN || status == ST_DROPPED))
        else $error("illegal status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(abs_x) && $stable(abs_y)
            && $stable(pointer_x) && $stable(pointer_y) && $stable(status)))
        else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_tracker_core ps2mt_checker #(
    .COORD_BITS (COORD_BITS)
) u_ps2mt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .abs_x     (abs_x),
    .abs_y     (abs_y),
    .pointer_x (pointer_x),
    .pointer_y (pointer_y)
);

// ----- tb/sv/testbench.sv -----
// self-checking bench for the ps/2 mouse packet tracker core
`timescale 1ns / 1ps

module testbench;
    import ps2mt_pkg::*;

    localparam int COORD_W   = COORD_BITS_DEF;
    localparam int QUEUE_CAP = FIFO_DEPTH_DEF;
    localparam int LATENCY   = 70;
    localparam int LIMIT     = 3_000_000;
    localparam int CALM_FROM = 12_000;
    localparam int CALM_TO   = 24_000;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
        logic       busy;
    } mouse_item_t;

    typedef struct packed {
        logic [1:0]         st;
        logic [BTN_W-1:0]   btn;
        logic [FRAC_W-1:0]  ax;
        logic [FRAC_W-1:0]  ay;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } host_report_t;

    typedef struct packed {
        logic [BTN_W-1:0]   btn;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } button_event_t;

    typedef struct packed {
        logic              idx;
        logic [SIZE_W-1:0] data;
    } reg_write_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_SCREEN_WIDTH;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 action = ACT_BYTE;
    logic [7:0]           data_byte = '0;
    logic                 host_busy = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           status;
    logic                 button_left;
    logic                 button_right;
    logic                 button_middle;
    logic [FRAC_W-1:0]    abs_x;
    logic [FRAC_W-1:0]    abs_y;
    logic [COORD_W-1:0]   pointer_x;
    logic [COORD_W-1:0]   pointer_y;

    ps2_mouse_packet_tracker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .host_busy     (host_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .button_left   (button_left),
        .button_right  (button_right),
        .button_middle (button_middle),
        .abs_x         (abs_x),
        .abs_y         (abs_y),
        .pointer_x     (pointer_x),
        .pointer_y     (pointer_y)
    );

    // stimulus and expectation stores
    mouse_item_t   pending_items[$];
    reg_write_t    reg_writes[$];
    host_report_t  expected_reports[$];

    // tracker mirror, starting from the reset state
    logic [SIZE_W-1:0]  width_reg = SIZE_W'(RESET_WIDTH);
    logic [SIZE_W-1:0]  height_reg = SIZE_W'(RESET_HEIGHT);
    logic [1:0]         pkt_phase = PH_FIRST;
    logic               drop_pkt = 1'b0;
    logic               tracking = 1'b0;
    logic [7:0]         head_b = '0;
    logic [7:0]         move_x_b = '0;
    logic [COORD_W-1:0] cur_x = COORD_W'(RESET_WIDTH / 2);
    logic [COORD_W-1:0] cur_y = COORD_W'(RESET_HEIGHT / 2);
    logic [BTN_W-1:0]   shown_btn = '0;
    logic [COORD_W-1:0] shown_x = COORD_W'(RESET_WIDTH / 2);
    logic [COORD_W-1:0] shown_y = COORD_W'(RESET_HEIGHT / 2);
    button_event_t      queued_events[$];

    int unsigned  cycles = 0;
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  gap_left = 0;
    int unsigned  ready_hold = 0;
    logic         calm;
    mouse_item_t  on_wire;
    reg_write_t   reg_on_wire;
    host_report_t want;
    logic [BTN_W-1:0] gen_btn = '0;

    assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("ps2_mouse_packet_tracker_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [COORD_W:0] fit_size(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return (COORD_W + 1)'(1);
        if (s > (1 << COORD_W))
            return (COORD_W + 1)'(1 << COORD_W);
        return s[COORD_W:0];
    endfunction

    function automatic logic [FRAC_W-1:0] to_fraction(input logic [COORD_W-1:0] v,
                                                      input logic [SIZE_W-1:0] s);
        logic [63:0] num;
        logic [63:0] q;
        num = 64'(v) << 32;
        q = num / 64'(fit_size(s));
        if (q > 64'hFFFF_FFFF)
            return '1;
        return q[FRAC_W-1:0];
    endfunction

    function automatic int move_of(input logic [7:0] b, input logic signed_move);
        if (signed_move && b[7])
            return int'(b) - 256;
        return int'(b);
    endfunction

    function automatic logic [COORD_W-1:0] pin(input int p, input logic [SIZE_W-1:0] s);
        int lim;
        lim = int'(fit_size(s));
        if (p < 0)
            return '0;
        if (p >= lim)
            return COORD_W'(lim - 1);
        return COORD_W'(p);
    endfunction

    task automatic track_item(input mouse_item_t it);
        host_report_t  r;
        button_event_t ev;
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] newest;
        r = '0;
        r.st = ST_NONE;
        if (it.act == ACT_BYTE)
        begin
            case (pkt_phase)
                PH_SECOND:
                begin
                    move_x_b = it.data;
                    pkt_phase = PH_THIRD;
                end
                PH_THIRD:
                begin
                    pkt_phase = PH_FIRST;
                    if (drop_pkt)
                        drop_pkt = 1'b0;
                    else
                    begin
                        btn = head_b[BTN_W-1:0];
                        tracking = 1'b1;
                        cur_x = pin(int'(cur_x) + move_of(move_x_b, head_b[FLAG_X_SIGN]),
                                    width_reg);
                        // screen y runs downwards, mouse y upwards
                        cur_y = pin(int'(cur_y) - move_of(it.data, head_b[FLAG_Y_SIGN]),
                                    height_reg);
                        newest = (queued_events.size() != 0) ? queued_events[$].btn
                                                              : shown_btn;
                        if (btn == newest)
                        begin
                            shown_btn = btn;
                            shown_x = cur_x;
                            shown_y = cur_y;
                        end
                        else if (queued_events.size() >= QUEUE_CAP)
                            r.st = ST_DROPPED;
                        else
                        begin
                            ev.btn = btn;
                            ev.x = cur_x;
                            ev.y = cur_y;
                            queued_events.push_back(ev);
                        end
                    end
                end
                default:
                begin
                    head_b = it.data;
                    pkt_phase = PH_SECOND;
                    drop_pkt = it.data[FLAG_X_OVF] | it.data[FLAG_Y_OVF]
                               | ~it.data[FLAG_ALWAYS_ONE];
                end
            endcase
        end
        else if (tracking && !it.busy)
        begin
            if (queued_events.size() != 0)
            begin
                ev = queued_events.pop_front();
                shown_btn = ev.btn;
                shown_x = ev.x;
                shown_y = ev.y;
            end
            r.st = ST_WRITTEN;
        end
        r.btn = shown_btn;
        r.ax = to_fraction(shown_x, width_reg);
        r.ay = to_fraction(shown_y, height_reg);
        r.px = cur_x;
        r.py = cur_y;
        expected_reports.push_back(r);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                want = expected_reports.pop_front();
                check_field("status", 64'(status), 64'(want.st));
                check_field("button_left", 64'(button_left), 64'(want.btn[0]));
                check_field("button_right", 64'(button_right), 64'(want.btn[1]));
                check_field("button_middle", 64'(button_middle), 64'(want.btn[2]));
                check_field("abs_x", 64'(abs_x), 64'(want.ax));
                check_field("abs_y", 64'(abs_y), 64'(want.ay));
                check_field("pointer_x", 64'(pointer_x), 64'(want.px));
                check_field("pointer_y", 64'(pointer_y), 64'(want.py));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------- drivers

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_item(on_wire);
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    on_wire = pending_items.pop_front();
                    action <= on_wire.act;
                    data_byte <= on_wire.data;
                    host_busy <= on_wire.busy;
                    in_valid <= 1'b1;
                    // gap after this item, long enough to land anywhere in the block's work
                    if (!calm && $urandom_range(0, 99) < 33)
                        gap_left <= $urandom_range(1, 100);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= 33);
            ready_hold <= $urandom_range(0, 30);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    reg_on_wire = reg_writes.pop_front();
                    cfg_index <= reg_on_wire.idx;
                    cfg_data <= reg_on_wire.data;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_item(input logic act, input logic [7:0] data, input logic busy);
        mouse_item_t it;
        it.act = act;
        it.data = data;
        it.busy = busy;
        pending_items.push_back(it);
    endtask

    task automatic add_packet(input logic [7:0] head, input logic [7:0] dx,
                              input logic [7:0] dy);
        add_item(ACT_BYTE, head, 1'($urandom_range(0, 1)));
        add_item(ACT_BYTE, dx, 1'($urandom_range(0, 1)));
        add_item(ACT_BYTE, dy, 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] good_head(input logic [BTN_W-1:0] btn, input logic xs,
                                             input logic ys);
        return {2'b00, ys, xs, 1'b1, btn};
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        reg_write_t wr;
        wait_drained();
        repeat (LATENCY) @(negedge clk);
        wr.idx = REG_SCREEN_WIDTH;
        wr.data = w;
        reg_writes.push_back(wr);
        wr.idx = REG_SCREEN_HEIGHT;
        wr.data = h;
        reg_writes.push_back(wr);
        do
            @(negedge clk);
        while (reg_writes.size() != 0 || cfg_valid);
    endtask

    task automatic add_random(input int count);
        int added;
        int pick;
        logic [7:0] hd;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // mostly repeat the buttons so both direct updates and queueing happen
                if ($urandom_range(0, 99) >= 60)
                    gen_btn = BTN_W'($urandom_range(0, 7));
                add_packet(good_head(gen_btn, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                added += 3;
            end
            else if (pick < 88)
            begin
                add_item(ACT_POLL, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                added++;
            end
            else if (pick < 94)
            begin
                // stray byte, throws the packet framing out of step
                add_item(ACT_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                hd = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1)
                    hd[FLAG_X_OVF + $urandom_range(0, 1)] = 1'b1;
                else
                    hd[FLAG_ALWAYS_ONE] = 1'b0;
                add_packet(hd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                added += 3;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset screen size
        add_item(ACT_POLL, 8'h00, 1'b0);          // poll before any packet
        add_item(ACT_POLL, 8'hFF, 1'b1);          // busy poll
        add_packet(good_head(3'b000, 1'b0, 1'b0), 8'h05, 8'h03);
        add_item(ACT_POLL, 8'h5A, 1'b0);          // poll with nothing queued
        add_packet(8'h48, 8'h10, 8'h10);          // x overflow
        add_packet(8'h07, 8'h20, 8'h20);          // always-one bit clear
        add_packet(good_head(3'b111, 1'b1, 1'b1), 8'h80, 8'h7F);
        add_packet(good_head(3'b111, 1'b1, 1'b1), 8'hFF, 8'hFF);
        add_packet(good_head(3'b111, 1'b0, 1'b0), 8'hFF, 8'h00);
        add_item(ACT_POLL, 8'h00, 1'b1);
        add_item(ACT_POLL, 8'hA5, 1'b0);
        add_packet(8'h88, 8'h00, 8'h00);          // y overflow

        set_screen(SIZE_W'(4096), SIZE_W'(4096));
        // drive the pointer to the right edge and down the screen, then let the host catch up
        repeat (20)
            add_packet(good_head(3'b000, 1'b0, 1'b1), 8'hFF, 8'h80);
        repeat (40)
            add_item(ACT_POLL, 8'($urandom_range(0, 255)), 1'b0);
        add_random(50);

        // shrinking under a stored position saturates the fractions
        set_screen(SIZE_W'(640), SIZE_W'(480));
        add_random(50);
        set_screen(SIZE_W'(1), SIZE_W'(1));
        add_random(40);
        set_screen(SIZE_W'(0), SIZE_W'(8191));
        add_random(40);
        set_screen(SIZE_W'(4097), SIZE_W'(2));
        add_random(40);
        set_screen(SIZE_W'(RESET_WIDTH), SIZE_W'(RESET_HEIGHT));
        add_random(50);

        // queue a run of alternating buttons, then drain it
        set_screen(SIZE_W'(4096), SIZE_W'(4096));
        for (int i = 0; i < 30; i++)
            add_packet(good_head((i % 2 == 0) ? 3'b001 : 3'b010, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1))),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (50)
            add_item(ACT_POLL, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);

        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("ps2_mouse_packet_tracker_core test passed");
        else
            $display("ps2_mouse_packet_tracker_core test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ps2mt_pkg.sv
hdl/ps2mt_fifo.sv
hdl/ps2mt_div.sv
hdl/ps2_mouse_packet_tracker_core.sv
hdl/ps2mt_checker.sv
tb/sv/testbench.sv
